[src/bfst_pkg.sv]
// Shared types and constants for the bidirectional flow statistics table.
package bfst_pkg;

   localparam int TableDepthDefault = 32;
   localparam int QueueDepth = 2;

   localparam logic CmdPacket = 1'b0;
   localparam logic CmdReport = 1'b1;

   localparam logic KindGlobal  = 1'b0;
   localparam logic KindSession = 1'b1;

   // classified item handed from front to back
   typedef struct packed {
      logic        report;
      logic [31:0] addr_lo;
      logic [31:0] addr_hi;
      logic [15:0] port_lo;
      logic [15:0] port_hi;
      logic [15:0] length;
      logic [7:0]  service;
   } work_type;

   // one result record
   typedef struct packed {
      logic        record_kind;
      logic [31:0] address_low;
      logic [31:0] address_high;
      logic [15:0] port_low;
      logic [15:0] port_high;
      logic [7:0]  session_service;
      logic [31:0] byte_total;
      logic [31:0] packet_total;
      logic [15:0] average_size;
      logic [31:0] dropped_total;
      logic        last_record;
   } record_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

[src/bfst_front.sv]
// Front end: accepts items, orders the key and queues the classified work.
module bfst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [119:0]      req_tdata,
   input  logic              req_tuser,
   output bfst_pkg::work_type work_data,
   output logic              work_valid,
   input  logic              work_take
);
   localparam int PtrW = $clog2(bfst_pkg::QueueDepth);

   bfst_pkg::work_type queue_ff [bfst_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]   count_ff;
   bfst_pkg::work_type item_in;
   logic [31:0] sa, da;
   logic [15:0] sp, dp;
   logic push, pop;

   always_comb begin
      sa = req_tdata[31:0];
      da = req_tdata[63:32];
      sp = req_tdata[79:64];
      dp = req_tdata[95:80];
      item_in.report  = (req_tuser == bfst_pkg::CmdReport);
      item_in.addr_lo = (da < sa) ? da : sa;
      item_in.addr_hi = (da < sa) ? sa : da;
      item_in.port_lo = (dp < sp) ? dp : sp;
      item_in.port_hi = (dp < sp) ? sp : dp;
      item_in.length  = req_tdata[111:96];
      item_in.service = req_tdata[119:112];
   end

   assign req_tready = (count_ff != (PtrW+1)'(bfst_pkg::QueueDepth));
   assign push = req_tvalid && req_tready;
   assign work_valid = (count_ff != '0);
   assign pop = work_valid && work_take;
   assign work_data = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == (PtrW+1)'(bfst_pkg::QueueDepth) |-> !push)
      else $error("front queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !pop)
      else $error("front queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("front queue count slip");
`endif
endmodule

[src/bfst_divider.sv]
// Restoring divider, one quotient bit per cycle, saturated to 16 bits.
module bfst_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff;
   logic [5:0]  step_ff;
   logic [32:0] trial;

   always_comb begin
      trial = {rem_ff[31:0], quo_ff[31]};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = trial - {1'b0, dvs_ff};
         quo_in = {quo_ff[30:0], 1'b1};
      end else begin
         rem_in = trial;
         quo_in = {quo_ff[30:0], 1'b0};
      end
   end

   assign busy = (step_ff != '0);
   assign quotient = (dvs_ff == '0) ? 16'd0 :
                     (quo_ff[31:16] != '0) ? 16'hFFFF : quo_ff[15:0];

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (reset) begin
         step_ff <= '0;
      end else if (start) begin
         step_ff <= 6'd32;
      end else if (busy) begin
         step_ff <= step_ff - 1'b1;
      end
   end
endmodule

[src/bfst_back.sv]
// Back end: table search, update, drop counting and report sequencing.
module bfst_back #(
   parameter int TableDepth = bfst_pkg::TableDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  bfst_pkg::work_type work_data,
   input  logic               work_valid,
   output logic               work_take,
   output bfst_pkg::record_type rec_data,
   output logic               rec_valid,
   input  logic               rec_take
);
   localparam int IdxW = $clog2(TableDepth) > 0 ? $clog2(TableDepth) : 1;
   localparam int CntW = $clog2(TableDepth + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CMP, S_HIT, S_DIV, S_AVG, S_RPT_G, S_RPT_GDIV,
      S_RPT_READ, S_RPT_EMIT, S_RPT_WAIT
   } state_type;

   logic [31:0] mem_alo  [TableDepth];
   logic [31:0] mem_ahi  [TableDepth];
   logic [31:0] mem_port [TableDepth];
   logic [7:0]  mem_svc  [TableDepth];
   logic [31:0] mem_byt  [TableDepth];
   logic [31:0] mem_pkt  [TableDepth];
   logic [15:0] mem_avg  [TableDepth];

   state_type   state_ff;
   logic [CntW-1:0] used_ff, idx_ff;
   logic [31:0] g_pkt_ff, g_byt_ff, g_drop_ff;
   logic [31:0] rd_alo_ff, rd_ahi_ff, rd_port_ff, rd_byt_ff, rd_pkt_ff;
   logic [7:0]  rd_svc_ff;
   logic [15:0] rd_avg_ff;
   logic [31:0] nb_ff, np_ff;
   bfst_pkg::work_type cur_ff;
   bfst_pkg::record_type rec_ff;
   logic        rec_valid_ff;
   logic        rec_load;
   logic        div_start;
   logic        div_busy;
   logic [15:0] div_q;
   logic [31:0] div_a, div_b;
   logic [IdxW-1:0] idx;
   logic        key_match;

   assign idx = idx_ff[IdxW-1:0];
   assign key_match = (rd_alo_ff == cur_ff.addr_lo) && (rd_ahi_ff == cur_ff.addr_hi) &&
                      (rd_port_ff == {cur_ff.port_hi, cur_ff.port_lo});
   assign work_take = (state_ff == S_IDLE) && work_valid;
   assign rec_data = rec_ff;
   assign rec_valid = rec_valid_ff;
   assign rec_load = ((state_ff == S_RPT_GDIV) && !div_busy && !rec_valid_ff) ||
                     ((state_ff == S_RPT_EMIT) && (!rec_valid_ff || rec_take));
   assign div_start = (state_ff == S_HIT) || (state_ff == S_RPT_G);
   assign div_a = (state_ff == S_HIT) ? nb_ff : g_byt_ff;
   assign div_b = (state_ff == S_HIT) ? np_ff : g_pkt_ff;

   bfst_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // table memories: one read port, one write port
   always_ff @(posedge clock) begin
      rd_alo_ff  <= mem_alo[idx];
      rd_ahi_ff  <= mem_ahi[idx];
      rd_port_ff <= mem_port[idx];
      rd_svc_ff  <= mem_svc[idx];
      rd_byt_ff  <= mem_byt[idx];
      rd_pkt_ff  <= mem_pkt[idx];
      rd_avg_ff  <= mem_avg[idx];
      // an empty table holds no valid entry, so stale read data is not taken as a match
      if (state_ff == S_CMP && (used_ff == '0 || !key_match) && idx_ff + 1'b1 >= used_ff
          && used_ff != CntW'(TableDepth)) begin
         mem_alo[used_ff[IdxW-1:0]]  <= cur_ff.addr_lo;
         mem_ahi[used_ff[IdxW-1:0]]  <= cur_ff.addr_hi;
         mem_port[used_ff[IdxW-1:0]] <= {cur_ff.port_hi, cur_ff.port_lo};
         mem_svc[used_ff[IdxW-1:0]]  <= cur_ff.service;
         mem_byt[used_ff[IdxW-1:0]]  <= {16'd0, cur_ff.length};
         mem_pkt[used_ff[IdxW-1:0]]  <= 32'd1;
         mem_avg[used_ff[IdxW-1:0]]  <= cur_ff.length;
      end
      if (state_ff == S_HIT) begin
         mem_byt[idx] <= nb_ff;
         mem_pkt[idx] <= np_ff;
      end
      if (state_ff == S_AVG) begin
         mem_avg[idx] <= div_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         idx_ff       <= '0;
         g_pkt_ff     <= '0;
         g_byt_ff     <= '0;
         g_drop_ff    <= '0;
         rec_valid_ff <= 1'b0;
      end else begin
         if (rec_valid_ff && rec_take && !rec_load) rec_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (work_valid) begin
                  cur_ff <= work_data;
                  idx_ff <= '0;
                  if (work_data.report) begin
                     state_ff <= S_RPT_G;
                  end else begin
                     g_byt_ff <= bfst_pkg::sat_add(g_byt_ff, {16'd0, work_data.length});
                     g_pkt_ff <= bfst_pkg::sat_add(g_pkt_ff, 32'd1);
                     if (used_ff == '0) begin
                        state_ff <= S_CMP;
                     end else begin
                        state_ff <= S_READ;
                     end
                  end
               end
            end
            S_READ: state_ff <= S_CMP;
            S_CMP: begin
               if (used_ff != '0 && idx_ff < used_ff && key_match) begin
                  nb_ff <= bfst_pkg::sat_add(rd_byt_ff, {16'd0, cur_ff.length});
                  np_ff <= bfst_pkg::sat_add(rd_pkt_ff, 32'd1);
                  state_ff <= S_HIT;
               end else if (idx_ff + 1'b1 < used_ff) begin
                  // advance the search
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_READ;
               end else begin
                  if (used_ff == CntW'(TableDepth)) begin
                     g_drop_ff <= bfst_pkg::sat_add(g_drop_ff, 32'd1);
                  end else begin
                     used_ff <= used_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_HIT: state_ff <= S_DIV;
            S_DIV: if (!div_busy) state_ff <= S_AVG;
            S_AVG: state_ff <= S_IDLE;
            S_RPT_G: state_ff <= S_RPT_GDIV;
            S_RPT_GDIV: begin
               if (!div_busy && !rec_valid_ff) begin
                  rec_ff.record_kind     <= bfst_pkg::KindGlobal;
                  rec_ff.address_low     <= '0;
                  rec_ff.address_high    <= '0;
                  rec_ff.port_low        <= '0;
                  rec_ff.port_high       <= '0;
                  rec_ff.session_service <= '0;
                  rec_ff.byte_total      <= g_byt_ff;
                  rec_ff.packet_total    <= g_pkt_ff;
                  rec_ff.average_size    <= div_q;
                  rec_ff.dropped_total   <= g_drop_ff;
                  rec_ff.last_record     <= (used_ff == '0);
                  rec_valid_ff <= 1'b1;
                  g_byt_ff  <= '0;
                  g_pkt_ff  <= '0;
                  g_drop_ff <= '0;
                  if (used_ff == '0) begin
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_RPT_READ;
                  end
               end
            end
            S_RPT_READ: state_ff <= S_RPT_EMIT;
            S_RPT_EMIT: begin
               if (!rec_valid_ff || rec_take) begin
                  rec_ff.record_kind     <= bfst_pkg::KindSession;
                  rec_ff.address_low     <= rd_alo_ff;
                  rec_ff.address_high    <= rd_ahi_ff;
                  rec_ff.port_low        <= rd_port_ff[15:0];
                  rec_ff.port_high       <= rd_port_ff[31:16];
                  rec_ff.session_service <= rd_svc_ff;
                  rec_ff.byte_total      <= rd_byt_ff;
                  rec_ff.packet_total    <= rd_pkt_ff;
                  rec_ff.average_size    <= rd_avg_ff;
                  rec_ff.dropped_total   <= '0;
                  rec_ff.last_record     <= (idx_ff + 1'b1 == used_ff);
                  rec_valid_ff <= 1'b1;
                  if (idx_ff + 1'b1 == used_ff) begin
                     used_ff  <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_RPT_READ;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CntW'(TableDepth))
      else $error("table count beyond depth");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      work_take |-> state_ff == S_IDLE)
      else $error("work taken while busy");
   a_rec_hold: assert property (@(posedge clock) disable iff (reset)
      rec_valid_ff && !rec_take |=> rec_valid_ff && $stable(rec_ff))
      else $error("record changed while stalled");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RPT_EMIT |-> idx_ff < used_ff)
      else $error("report index beyond table");
`endif
endmodule

[src/bidirectional_flow_stats_table.sv]
// Top level of the bidirectional flow statistics table.
//  channel | dir | payload
//  req_*   | in  | tuser cmd, tdata header fields
//  rsp_*   | out | tuser record_kind, tlast last_record, tdata record fields
// A packet passes through the input queue, then is searched against the table one entry
// at a time (read, then compare); a hit adds the 32-step divider for the average.
// A report runs the divider for the global record, then reads and emits one session
// record per entry. Reset clears the counters and the entry count; no sweep.
// A two-deep queue holds items while the back end works; results wait in a
// register and stall the report sequence only.
module bidirectional_flow_stats_table #(
   parameter int TABLE_DEPTH = bfst_pkg::TableDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // source_address, dest_address, source_port_num, dest_port_num,
   // packet_length, service_kind
   input  logic [119:0] req_tdata,
   input  logic         req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // address_low, address_high, port_low, port_high, session_service,
   // byte_total, packet_total, average_size, dropped_total, zero pad
   output logic [223:0] rsp_tdata,
   output logic         rsp_tuser,   // record_kind
   output logic         rsp_tlast    // last_record
);
   bfst_pkg::work_type   work_data;
   bfst_pkg::record_type rec;
   logic work_valid, work_take;

   bfst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .work_data  (work_data),
      .work_valid (work_valid),
      .work_take  (work_take)
   );

   bfst_back #(.TableDepth(TABLE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_data  (work_data),
      .work_valid (work_valid),
      .work_take  (work_take),
      .rec_data   (rec),
      .rec_valid  (rsp_tvalid),
      .rec_take   (rsp_tready)
   );

   assign rsp_tuser = rec.record_kind;
   assign rsp_tlast = rec.last_record;
   assign rsp_tdata = {8'd0, rec.dropped_total, rec.average_size, rec.packet_total,
                       rec.byte_total, rec.session_service, rec.port_high,
                       rec.port_low, rec.address_high, rec.address_low};
endmodule
